/* hdl/gsns_pkg.sv */
`timescale 1ns / 1ps
package gsns_pkg;

    // Command codes of an input transaction
    localparam logic [1:0] CMD_WRITE  = 2'd0;
    localparam logic [1:0] CMD_READ   = 2'd1;
    localparam logic [1:0] CMD_SEARCH = 2'd2;

    // Register indexes on the configuration port
    localparam logic REG_ROW_COUNT    = 1'b0;
    localparam logic REG_COLUMN_COUNT = 1'b1;

    localparam logic [4:0] ROW_COUNT_RESET    = 5'd16;
    localparam logic [4:0] COLUMN_COUNT_RESET = 5'd16;

    // Read sequence steps: cell first, then the four neighbors
    localparam logic [2:0] STEP_CELL  = 3'd0;
    localparam logic [2:0] STEP_UP    = 3'd1;
    localparam logic [2:0] STEP_DOWN  = 3'd2;
    localparam logic [2:0] STEP_LEFT  = 3'd3;
    localparam logic [2:0] STEP_RIGHT = 3'd4;

    typedef struct packed {
        logic [1:0]         command;
        logic [3:0]         col_x;
        logic [3:0]         row_y;
        logic signed [31:0] data_value;
    } in_item_t;

    typedef struct packed {
        logic               status;
        logic signed [31:0] cell_value;
        logic signed [31:0] up_value;
        logic signed [31:0] down_value;
        logic signed [31:0] left_value;
        logic signed [31:0] right_value;
        logic [3:0]         neighbor_mask;
        logic [3:0]         found_x;
        logic [3:0]         found_y;
    } out_item_t;

    typedef struct packed {
        logic [4:0] row_count;
        logic [4:0] column_count;
    } cfg_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_EXEC,
        ST_READ,
        ST_WAIT,
        ST_SEARCH,
        ST_DONE
    } state_t;

endpackage

/* hdl/gsns_cfg.sv */
`timescale 1ns / 1ps
module gsns_cfg (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          psel,
    input  logic          penable,
    input  logic          pwrite,
    input  logic [2:0]    paddr,
    input  logic [31:0]   pwdata,
    output logic [31:0]   prdata,
    output logic          pready,
    output gsns_pkg::cfg_t cfg
);
    import gsns_pkg::*;

    logic [4:0] row_count_reg;
    logic [4:0] column_count_reg;
    logic       wr_en;
    logic       reg_sel;

    assign pready  = 1'b1;
    assign wr_en   = psel & penable & pwrite;
    assign reg_sel = paddr[2];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_count_reg    <= ROW_COUNT_RESET;
            column_count_reg <= COLUMN_COUNT_RESET;
        end else if (wr_en) begin
            case (reg_sel)
                REG_ROW_COUNT:    row_count_reg    <= pwdata[4:0];
                REG_COLUMN_COUNT: column_count_reg <= pwdata[4:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_sel)
            REG_ROW_COUNT:    prdata = {27'd0, row_count_reg};
            REG_COLUMN_COUNT: prdata = {27'd0, column_count_reg};
            default:          prdata = '0;
        endcase
    end

    assign cfg.row_count    = row_count_reg;
    assign cfg.column_count = column_count_reg;

endmodule

/* hdl/gsns_mem.sv */
`timescale 1ns / 1ps
module gsns_mem #(
    parameter int unsigned DEPTH = 256,
    parameter int unsigned AW    = 8
) (
    input  logic          aclk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [31:0]   wdata,
    input  logic [AW-1:0] raddr,
    output logic [31:0]   rdata
);
    logic [31:0] mem [DEPTH];
    logic [31:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

/* hdl/gsns_ctrl.sv */
`timescale 1ns / 1ps
module gsns_ctrl #(
    parameter int unsigned MAX_ROWS = 16,
    parameter int unsigned MAX_COLS = 16,
    parameter int unsigned DEPTH    = 256,
    parameter int unsigned AW       = 8
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  gsns_pkg::cfg_t       cfg,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  gsns_pkg::in_item_t   s_data,
    output logic                 m_valid,
    input  logic                 m_ready,
    output gsns_pkg::out_item_t  m_data,
    output logic                 mem_we,
    output logic [AW-1:0]        mem_waddr,
    output logic [31:0]          mem_wdata,
    output logic [AW-1:0]        mem_raddr,
    input  logic [31:0]          mem_rdata
);
    import gsns_pkg::*;

    localparam logic [AW-1:0] CLR_LAST = AW'(DEPTH - 1);

    state_t          state_reg,    state_next;
    in_item_t        item_reg,     item_next;
    out_item_t       res_reg,      res_next;
    out_item_t       m_data_reg,   m_data_next;
    logic            m_valid_reg,  m_valid_next;
    logic [AW-1:0]   clr_addr_reg, clr_addr_next;
    logic [2:0]      step_reg,     step_next;
    logic            rd_pend_reg,  rd_pend_next;
    logic [2:0]      rd_tag_reg,   rd_tag_next;
    logic [3:0]      present_reg,  present_next;
    logic [4:0]      r_reg,        r_next;
    logic [4:0]      c_reg,        c_next;
    logic            cmp_pend_reg, cmp_pend_next;
    logic [4:0]      cmp_r_reg,    cmp_r_next;
    logic [4:0]      cmp_c_reg,    cmp_c_next;
    logic            scan_end_reg, scan_end_next;

    logic [4:0]      nr;
    logic [4:0]      nc;
    logic [4:0]      x5;
    logic [4:0]      y5;
    logic            in_grid;
    logic [3:0]      nb_mask;
    logic            out_free;
    logic            hit;

    function automatic logic [AW-1:0] cell_addr(input logic [4:0] r, input logic [4:0] c);
        return AW'(32'(r) * MAX_COLS + 32'(c));
    endfunction

    // Clamp the configured size to the storage size
    assign nr = (32'(cfg.row_count) > MAX_ROWS) ? 5'(MAX_ROWS) : cfg.row_count;
    assign nc = (32'(cfg.column_count) > MAX_COLS) ? 5'(MAX_COLS) : cfg.column_count;

    assign x5      = {1'b0, item_reg.col_x};
    assign y5      = {1'b0, item_reg.row_y};
    assign in_grid = (x5 < nc) && (y5 < nr);
    assign nb_mask = {(x5 + 5'd1) < nc, x5 != 5'd0, (y5 + 5'd1) < nr, y5 != 5'd0};
    assign out_free = !m_valid_reg || m_ready;
    assign hit      = cmp_pend_reg && (mem_rdata == item_reg.data_value);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_CLEAR;
            m_valid_reg  <= 1'b0;
            clr_addr_reg <= '0;
            rd_pend_reg  <= 1'b0;
            cmp_pend_reg <= 1'b0;
            scan_end_reg <= 1'b0;
            step_reg     <= STEP_CELL;
        end else begin
            state_reg    <= state_next;
            m_valid_reg  <= m_valid_next;
            clr_addr_reg <= clr_addr_next;
            rd_pend_reg  <= rd_pend_next;
            cmp_pend_reg <= cmp_pend_next;
            scan_end_reg <= scan_end_next;
            step_reg     <= step_next;
        end
        item_reg    <= item_next;
        res_reg     <= res_next;
        m_data_reg  <= m_data_next;
        rd_tag_reg  <= rd_tag_next;
        present_reg <= present_next;
        r_reg       <= r_next;
        c_reg       <= c_next;
        cmp_r_reg   <= cmp_r_next;
        cmp_c_reg   <= cmp_c_next;
    end

    always_comb begin
        state_next    = state_reg;
        item_next     = item_reg;
        res_next      = res_reg;
        m_data_next   = m_data_reg;
        m_valid_next  = m_valid_reg;
        clr_addr_next = clr_addr_reg;
        step_next     = step_reg;
        rd_pend_next  = 1'b0;
        rd_tag_next   = rd_tag_reg;
        present_next  = present_reg;
        r_next        = r_reg;
        c_next        = c_reg;
        cmp_pend_next = 1'b0;
        cmp_r_next    = cmp_r_reg;
        cmp_c_next    = cmp_c_reg;
        scan_end_next = scan_end_reg;
        s_ready       = 1'b0;
        mem_we        = 1'b0;
        mem_waddr     = clr_addr_reg;
        mem_wdata     = '0;
        mem_raddr     = cell_addr(y5, x5);

        // Land read data of the previous cycle in its result slot
        if (rd_pend_reg) begin
            case (rd_tag_reg)
                STEP_CELL:  res_next.cell_value  = mem_rdata;
                STEP_UP:    if (present_reg[0]) res_next.up_value    = mem_rdata;
                STEP_DOWN:  if (present_reg[1]) res_next.down_value  = mem_rdata;
                STEP_LEFT:  if (present_reg[2]) res_next.left_value  = mem_rdata;
                STEP_RIGHT: if (present_reg[3]) res_next.right_value = mem_rdata;
                default: ;
            endcase
        end

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            ST_CLEAR: begin
                mem_we        = 1'b1;
                clr_addr_next = clr_addr_reg + AW'(1);
                if (clr_addr_reg == CLR_LAST) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    item_next  = s_data;
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                res_next        = '0;
                res_next.status = 1'b1;
                state_next      = ST_DONE;
                case (item_reg.command)
                    CMD_WRITE: begin
                        if (in_grid) begin
                            mem_we          = 1'b1;
                            mem_waddr       = cell_addr(y5, x5);
                            mem_wdata       = item_reg.data_value;
                            res_next.status = 1'b0;
                        end
                    end
                    CMD_READ: begin
                        if (in_grid) begin
                            res_next.status        = 1'b0;
                            res_next.neighbor_mask = nb_mask;
                            present_next           = nb_mask;
                            step_next              = STEP_CELL;
                            state_next             = ST_READ;
                        end
                    end
                    CMD_SEARCH: begin
                        if (nr != 5'd0 && nc != 5'd0) begin
                            r_next        = '0;
                            c_next        = '0;
                            scan_end_next = 1'b0;
                            state_next    = ST_SEARCH;
                        end
                    end
                    default: ;
                endcase
            end
            ST_READ: begin
                // Absent neighbors read the cell itself; their data is dropped
                case (step_reg)
                    STEP_UP:
                        if (present_reg[0]) mem_raddr = cell_addr(y5 - 5'd1, x5);
                    STEP_DOWN:
                        if (present_reg[1]) mem_raddr = cell_addr(y5 + 5'd1, x5);
                    STEP_LEFT:
                        if (present_reg[2]) mem_raddr = cell_addr(y5, x5 - 5'd1);
                    STEP_RIGHT:
                        if (present_reg[3]) mem_raddr = cell_addr(y5, x5 + 5'd1);
                    default: ;
                endcase
                rd_pend_next = 1'b1;
                rd_tag_next  = step_reg;
                if (step_reg == STEP_RIGHT) begin
                    state_next = ST_WAIT;
                end else begin
                    step_next = step_reg + 3'd1;
                end
            end
            ST_WAIT: begin
                state_next = ST_DONE;
            end
            ST_SEARCH: begin
                if (hit) begin
                    res_next.status  = 1'b0;
                    res_next.found_x = cmp_c_reg[3:0];
                    res_next.found_y = cmp_r_reg[3:0];
                    state_next       = ST_DONE;
                end else if (scan_end_reg) begin
                    state_next = ST_DONE;
                end else begin
                    mem_raddr     = cell_addr(r_reg, c_reg);
                    cmp_pend_next = 1'b1;
                    cmp_r_next    = r_reg;
                    cmp_c_next    = c_reg;
                    if ((c_reg + 5'd1) == nc) begin
                        c_next = '0;
                        if ((r_reg + 5'd1) == nr) begin
                            scan_end_next = 1'b1;
                        end else begin
                            r_next = r_reg + 5'd1;
                        end
                    end else begin
                        c_next = c_reg + 5'd1;
                    end
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_data_next  = res_reg;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

`ifndef SYNTHESIS
    a_we_state: assert property (@(posedge aclk) disable iff (!aresetn)
        mem_we |-> (state_reg == ST_CLEAR || state_reg == ST_EXEC))
        else $error("memory written outside clear or execute");

    a_accept_exec: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> (state_reg == ST_EXEC))
        else $error("accepted transaction not executed");

    a_load_done: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> ($past(state_reg) == ST_DONE))
        else $error("result loaded outside done state");

    a_fail_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_data_reg.status) |->
            (m_data_reg.neighbor_mask == 4'd0 && m_data_reg.found_x == 4'd0 &&
             m_data_reg.found_y == 4'd0 && m_data_reg.cell_value == 32'sd0))
        else $error("failed result carries nonzero fields");

    a_rd_pend: assert property (@(posedge aclk) disable iff (!aresetn)
        rd_pend_reg |-> (state_reg == ST_READ || state_reg == ST_WAIT))
        else $error("read data pending outside read sequence");
`endif

endmodule

/* hdl/grid_store_with_neighbor_search_top.sv */
`timescale 1ns / 1ps
// Grid store with neighbor search: a MAX_ROWS x MAX_COLS grid of signed 32-bit
// cells held in one simple dual-port synchronous RAM (one write and one read a cycle,
// read data registered). After reset the block sweeps the RAM to zero, one cell a
// cycle, over all MAX_ROWS*MAX_COLS cells (256 at the defaults); s_ready stays low
// during the sweep while configuration writes are taken as usual. Each input
// transaction yields one result transaction, and a new one is accepted only once
// the previous result is loaded into the output register. The RAM read port is
// single: a read of a cell and its four neighbors makes one RAM read per value,
// and a search compares one cell per cycle in row-major order, stopping at the
// first match. A finished result sits in the output register, so the next
// transaction is accepted while it waits; if that register is still full when the
// following result is ready, the block holds until it drains. Registers (APB,
// 4-byte spaced): row_count at 0x0 and column_count at 0x4, both 5 bits, reset 16;
// sizes above the parameters act as the parameters.
module grid_store_with_neighbor_search_top #(
    parameter int unsigned MAX_ROWS = 16,
    parameter int unsigned MAX_COLS = 16
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    // APB configuration
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [2:0]           paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready,
    // Command transactions
    input  logic                 s_valid,
    output logic                 s_ready,
    input  gsns_pkg::in_item_t   s_data,
    // Result transactions
    output logic                 m_valid,
    input  logic                 m_ready,
    output gsns_pkg::out_item_t  m_data
);
    import gsns_pkg::*;

    localparam int unsigned DEPTH = MAX_ROWS * MAX_COLS;
    localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    cfg_t          cfg;
    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    logic [31:0]   mem_wdata;
    logic [AW-1:0] mem_raddr;
    logic [31:0]   mem_rdata;

    // Size registers
    gsns_cfg u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // Cell storage, row-major
    gsns_mem #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_mem (
        .aclk  (aclk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    // Command sequencer: clear sweep, write, neighbor read, scan
    gsns_ctrl #(
        .MAX_ROWS (MAX_ROWS),
        .MAX_COLS (MAX_COLS),
        .DEPTH    (DEPTH),
        .AW       (AW)
    ) u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .mem_we    (mem_we),
        .mem_waddr (mem_waddr),
        .mem_wdata (mem_wdata),
        .mem_raddr (mem_raddr),
        .mem_rdata (mem_rdata)
    );

endmodule
